@@ rtl/core/bda_pkg.sv @@
// Shared types and constants for the box downscale average unit.
`timescale 1ns / 1ps

package bda_pkg;

    localparam int CHANNEL_BITS   = 8;
    localparam int NUM_CHANNELS   = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int FACTOR_BITS    = 5;
    localparam int QUOT_BITS      = CHANNEL_BITS;
    localparam int STEP_BITS      = $clog2(QUOT_BITS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch pixel, issue line store read, advance counters
        logic acc;        // add pixel to read sums and write back
        logic div_start;  // load dividers with the finished block sums
        logic div_step;   // one quotient bit per channel
        logic out_load;   // move quotients into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;       // current pixel completes a block inside the used area
        logic out_free;   // output register can take a result this cycle
    } status_t;

endpackage

@@ rtl/core/bda_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bda_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bda_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high, quotient known to fit.
`timescale 1ns / 1ps

module bda_div #(
    parameter int NUM_BITS = 16,
    parameter int DEN_BITS = 10
) (
    input  logic                           clk,
    input  logic                           start,
    input  logic                           step,
    input  logic [NUM_BITS-1:0]            dividend,
    input  logic [DEN_BITS-1:0]            divisor,
    output logic [bda_pkg::QUOT_BITS-1:0]  quotient
);

    localparam int DW = DEN_BITS + bda_pkg::QUOT_BITS;

    logic [DW-1:0]                  rem_reg, rem_next;
    logic [DW-1:0]                  den_reg, den_next;
    logic [bda_pkg::QUOT_BITS-1:0]  quo_reg, quo_next;

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start)
        begin
            rem_next = DW'(dividend);
            den_next = DW'(divisor) << (bda_pkg::QUOT_BITS - 1);
            quo_next = '0;
        end
        else if (step)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_next = rem_reg - den_reg;
                quo_next = {quo_reg[bda_pkg::QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[bda_pkg::QUOT_BITS-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/core/bda_ctrl.sv @@
// Controller state machine: pixel accept, accumulate, divide, output load.
`timescale 1ns / 1ps

module bda_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bda_pkg::status_t status,
    output bda_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [bda_pkg::STEP_BITS-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.emit)
                begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == bda_pkg::STEP_BITS'(bda_pkg::QUOT_BITS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ rtl/core/bda_datapath.sv @@
// Datapath: config registers, position counters, line store, dividers, output register.
`timescale 1ns / 1ps

module bda_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [bda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     red_in,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     green_in,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     blue_in,
    input  bda_pkg::cmd_t                        cmd,
    output bda_pkg::status_t                     status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     red_out,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     green_out,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     blue_out,
    output logic                                 frame_done
);

    localparam int CB        = bda_pkg::CHANNEL_BITS;
    localparam int NCH       = bda_pkg::NUM_CHANNELS;
    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int FACT_BITS = $clog2(MAX_FACTOR + 1);
    localparam int BLK_BITS  = $clog2(MAX_FACTOR);
    localparam int COL_BITS  = $clog2(MAX_WIDTH + 2 * MAX_FACTOR);
    localparam int ROW_BITS  = $clog2((1 << bda_pkg::CFG_DATA_BITS) + 2 * MAX_FACTOR);
    localparam int SUM_BITS  = CB + 2 * BLK_BITS;
    localparam int SQ_BITS   = 2 * FACT_BITS;

    // configuration
    logic [bda_pkg::CFG_DATA_BITS-1:0] width_reg, height_reg;
    logic [bda_pkg::FACTOR_BITS-1:0]   factor_reg;
    logic                              cfg_hit;

    assign cfg_hit = cfg_valid && (cfg_index == bda_pkg::REG_WIDTH ||
                                   cfg_index == bda_pkg::REG_HEIGHT ||
                                   cfg_index == bda_pkg::REG_FACTOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            factor_reg <= 5'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bda_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bda_pkg::REG_HEIGHT: height_reg <= cfg_data;
                bda_pkg::REG_FACTOR: factor_reg <= cfg_data[bda_pkg::FACTOR_BITS-1:0];
                default:             ;
            endcase
        end
    end

    logic [FACT_BITS-1:0] eff_f;
    logic [COL_BITS-1:0]  eff_w;
    logic [ROW_BITS-1:0]  eff_h;

    always_comb
    begin
        if (factor_reg == '0)
            eff_f = FACT_BITS'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            eff_f = FACT_BITS'(MAX_FACTOR);
        else
            eff_f = FACT_BITS'(factor_reg);

        if (width_reg == '0)
            eff_w = COL_BITS'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = COL_BITS'(MAX_WIDTH);
        else
            eff_w = COL_BITS'(width_reg);

        if (height_reg == '0)
            eff_h = ROW_BITS'(1);
        else
            eff_h = ROW_BITS'(height_reg);
    end

    // position counters
    logic [COL_BITS-1:0]  in_col_reg, col_base_reg;
    logic [ROW_BITS-1:0]  in_row_reg, row_base_reg;
    logic [BLK_BITS-1:0]  cib_reg, rib_reg;
    logic [ADDR_BITS-1:0] ocol_reg;

    logic [COL_BITS-1:0]  f_col, col_end, col_next_end;
    logic [ROW_BITS-1:0]  f_row, row_end, row_next_end;
    logic [BLK_BITS-1:0]  blk_last;
    logic                 cib_wrap, rib_wrap, row_wrap, frame_wrap;
    logic                 used, first, last, done;

    assign f_col        = COL_BITS'(eff_f);
    assign f_row        = ROW_BITS'(eff_f);
    assign blk_last     = BLK_BITS'(eff_f - 1'b1);
    assign col_end      = col_base_reg + f_col - 1'b1;
    assign row_end      = row_base_reg + f_row - 1'b1;
    assign col_next_end = col_end + f_col;
    assign row_next_end = row_end + f_row;
    assign cib_wrap     = (cib_reg == blk_last);
    assign rib_wrap     = (rib_reg == blk_last);
    assign row_wrap     = (in_col_reg == eff_w - 1'b1);
    assign frame_wrap   = (in_row_reg == eff_h - 1'b1);
    // pixel lies in a block that fits wholly inside the frame
    assign used         = (col_end < eff_w) && (row_end < eff_h);
    assign first        = (cib_reg == '0) && (rib_reg == '0);
    assign last         = cib_wrap && rib_wrap;
    // last whole block of the frame when no further block fits either way
    assign done         = (col_next_end >= eff_w) && (row_next_end >= eff_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            col_base_reg <= '0;
            cib_reg      <= '0;
            ocol_reg     <= '0;
            in_row_reg   <= '0;
            row_base_reg <= '0;
            rib_reg      <= '0;
        end
        else if (cfg_hit)
        begin
            in_col_reg   <= '0;
            col_base_reg <= '0;
            cib_reg      <= '0;
            ocol_reg     <= '0;
            in_row_reg   <= '0;
            row_base_reg <= '0;
            rib_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            if (row_wrap)
            begin
                in_col_reg   <= '0;
                col_base_reg <= '0;
                cib_reg      <= '0;
                ocol_reg     <= '0;
                if (frame_wrap)
                begin
                    in_row_reg   <= '0;
                    row_base_reg <= '0;
                    rib_reg      <= '0;
                end
                else
                begin
                    in_row_reg <= in_row_reg + 1'b1;
                    if (rib_wrap)
                    begin
                        rib_reg      <= '0;
                        row_base_reg <= row_base_reg + f_row;
                    end
                    else
                    begin
                        rib_reg <= rib_reg + 1'b1;
                    end
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
                if (cib_wrap)
                begin
                    cib_reg      <= '0;
                    ocol_reg     <= ocol_reg + 1'b1;
                    col_base_reg <= col_base_reg + f_col;
                end
                else
                begin
                    cib_reg <= cib_reg + 1'b1;
                end
            end
        end
    end

    // per-pixel flags and payload held for the accumulate cycle
    logic                 used_reg, first_reg, last_reg, done_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CB-1:0]        pix_reg [NCH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            used_reg <= used;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            first_reg  <= first;
            done_reg   <= done;
            addr_reg   <= ocol_reg;
            pix_reg[0] <= red_in;
            pix_reg[1] <= green_in;
            pix_reg[2] <= blue_in;
        end
    end

    // line store of per-column channel sums
    logic [NCH*SUM_BITS-1:0] rd_sums, wr_sums;

    bda_ram #(
        .WIDTH (NCH * SUM_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.acc && used_reg),
        .waddr (addr_reg),
        .wdata (wr_sums),
        .re    (cmd.accept),
        .raddr (ocol_reg),
        .rdata (rd_sums)
    );

    logic [SQ_BITS-1:0] area;
    logic [CB-1:0]      quo [NCH];

    assign area = SQ_BITS'(eff_f) * SQ_BITS'(eff_f);

    for (genvar c = 0; c < NCH; c++)
    begin : g_chan
        always_comb
        begin
            // first pixel of a block overwrites the stale sum
            if (first_reg)
                wr_sums[c*SUM_BITS +: SUM_BITS] = SUM_BITS'(pix_reg[c]);
            else
                wr_sums[c*SUM_BITS +: SUM_BITS] = rd_sums[c*SUM_BITS +: SUM_BITS]
                                                  + SUM_BITS'(pix_reg[c]);
        end

        bda_div #(
            .NUM_BITS (SUM_BITS),
            .DEN_BITS (SQ_BITS)
        ) u_div (
            .clk      (clk),
            .start    (cmd.div_start),
            .step     (cmd.div_step),
            .dividend (wr_sums[c*SUM_BITS +: SUM_BITS]),
            .divisor  (area),
            .quotient (quo[c])
        );
    end

    // output register
    logic          out_valid_reg;
    logic          done_out_reg;
    logic [CB-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            red_reg      <= quo[0];
            green_reg    <= quo[1];
            blue_reg     <= quo[2];
            done_out_reg <= done_reg;
        end
    end

    assign status.emit     = used_reg && last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign frame_done = done_out_reg;

endmodule

@@ rtl/core/box_downscale_average_unit.sv @@
// Top level of the box-filter integer-factor RGB image downscaler.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (width, height, factor)
//  pixel in | in_valid / in_ready    | red_in, green_in, blue_in
//  pixel out| out_valid / out_ready  | red_out, green_out, blue_out, frame_done
//
// Each input transaction is a line store read, then an add and write back.
// A pixel that completes a block then runs the dividers (one quotient bit per cycle
// per channel) and loads the output register once that register is free.
// A new input transaction is taken while a result waits in the output register;
// the next result stalls only if that register is still full.
// No clearing pass after reset: the first pixel of every block overwrites its sums.
`timescale 1ns / 1ps

module box_downscale_average_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     red_in,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     green_in,
    input  logic [bda_pkg::CHANNEL_BITS-1:0]     blue_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     red_out,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     green_out,
    output logic [bda_pkg::CHANNEL_BITS-1:0]     blue_out,
    output logic                                 frame_done
);

    bda_pkg::cmd_t    cmd;
    bda_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bda_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_done (frame_done)
    );

endmodule

@@ bench/tb_box_downscale_average_unit.sv @@
// Self-checking testbench for the box downscale average unit.
`timescale 1ns / 1ps

module tb_box_downscale_average_unit;

    import bda_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_FACTOR   = 16;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 380;
    localparam int CALM_ITEMS   = 60;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  done;
    } box_mean_t;

    class box_mean_scoreboard;
        logic [CFG_DATA_BITS-1:0] width_reg;
        logic [CFG_DATA_BITS-1:0] height_reg;
        logic [FACTOR_BITS-1:0]   factor_reg;
        int unsigned block_sums [MAX_WIDTH][NUM_CHANNELS];
        int unsigned in_col;
        int unsigned in_row;
        int unsigned col_in_blk;
        int unsigned row_in_blk;
        int unsigned out_col;
        box_mean_t   expected_means [$];
        int          errors;

        function new();
            width_reg  = CFG_DATA_BITS'(640);
            height_reg = CFG_DATA_BITS'(480);
            factor_reg = FACTOR_BITS'(2);
            errors     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            in_col     = 0;
            in_row     = 0;
            col_in_blk = 0;
            row_in_blk = 0;
            out_col    = 0;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg  = data;
                REG_HEIGHT: height_reg = data;
                REG_FACTOR: factor_reg = data[FACTOR_BITS-1:0];
                default:    return;
            endcase
            restart_frame();
        endfunction

        function void accumulate_pixel(chan_t r, chan_t g, chan_t b);
            int unsigned f;
            int unsigned w;
            int unsigned h;
            int unsigned used_w;
            int unsigned used_h;
            int unsigned slot;
            int unsigned chan [NUM_CHANNELS];
            int          c;
            box_mean_t   mean;
            f = (factor_reg == 0) ? 1 : (factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            used_w = (w / f) * f;
            used_h = (h / f) * f;
            chan[0] = r;
            chan[1] = g;
            chan[2] = b;
            if (in_col < used_w && in_row < used_h)
            begin
                slot = out_col % MAX_WIDTH;
                for (c = 0; c < NUM_CHANNELS; c++)
                begin
                    // first pixel of a square overwrites the stale column sum
                    if (col_in_blk == 0 && row_in_blk == 0)
                        block_sums[slot][c] = chan[c];
                    else
                        block_sums[slot][c] += chan[c];
                end
                if (col_in_blk == f - 1 && row_in_blk == f - 1)
                begin
                    mean.red   = chan_t'(block_sums[slot][0] / (f * f));
                    mean.green = chan_t'(block_sums[slot][1] / (f * f));
                    mean.blue  = chan_t'(block_sums[slot][2] / (f * f));
                    mean.done  = (in_row == used_h - 1 && in_col == used_w - 1);
                    expected_means.push_back(mean);
                end
            end
            col_in_blk++;
            if (col_in_blk >= f)
            begin
                col_in_blk = 0;
                out_col++;
            end
            in_col++;
            if (in_col >= w)
            begin
                in_col     = 0;
                col_in_blk = 0;
                out_col    = 0;
                row_in_blk++;
                if (row_in_blk >= f)
                    row_in_blk = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row     = 0;
                    row_in_blk = 0;
                end
            end
        endfunction

        function void flag(string field, int want, int got);
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
        endfunction

        function void check_result(box_mean_t got);
            box_mean_t want;
            if (expected_means.size() == 0)
            begin
                $error("output pixel with nothing expected: r=%0d g=%0d b=%0d done=%0d",
                       got.red, got.green, got.blue, got.done);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            if (got.red !== want.red)
                flag("red_out", want.red, got.red);
            if (got.green !== want.green)
                flag("green_out", want.green, got.green);
            if (got.blue !== want.blue)
                flag("blue_out", want.blue, got.blue);
            if (got.done !== want.done)
                flag("frame_done", want.done, got.done);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    chan_t                     red_in;
    chan_t                     green_in;
    chan_t                     blue_in;
    logic                      out_valid;
    logic                      out_ready;
    chan_t                     red_out;
    chan_t                     green_out;
    chan_t                     blue_out;
    logic                      frame_done;

    box_mean_scoreboard sb = new();

    bit calm;
    bit src_idle;
    int hold_requests;

    box_downscale_average_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_done (frame_done)
    );

    always #4 clk = ~clk;

    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        if (src_idle && !calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do @(posedge clk); while (!in_ready);
        sb.accumulate_pixel(r, g, b);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.note_config(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int f);
        logic [CFG_DATA_BITS-FACTOR_BITS-1:0] upper;
        upper = (CFG_DATA_BITS-FACTOR_BITS)'($urandom_range(0, 255));
        write_reg(REG_WIDTH, CFG_DATA_BITS'(w), 1'b0);
        write_reg(REG_HEIGHT, CFG_DATA_BITS'(h), 1'b0);
        // upper data bits are don't-care for the factor register
        write_reg(REG_FACTOR, {upper, FACTOR_BITS'(f)}, 1'b1);
    endtask

    // Drop valid, wait for all means, then let any result-free work finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic chan_t pick_channel();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return chan_t'($urandom_range(0, 255));
    endfunction

    task automatic send_random_pixels(input int n);
        repeat (n)
            send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // Result side: check each transaction, idle in bursts, serve hold-off requests.
    initial
    begin : result_sink
        int        stall_left;
        int        holds_done;
        box_mean_t got;
        stall_left = 0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {red_out, green_out, blue_out, frame_done};
                sb.check_result(got);
            end
            if (stall_left == 0 && holds_done != hold_requests)
            begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int n;
        int f;
        int ef;
        int w;
        int h;
        int ew;
        int eh;
        int sel;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_WIDTH;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        red_in        <= '0;
        green_in      <= '0;
        blue_in       <= '0;
        out_ready     <= 1'b0;
        calm          <= 1'b0;
        src_idle      <= 1'b1;
        hold_requests <= 0;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: a couple of pixels on the first row, no output yet
        send_pixel(8'hFF, 8'h00, 8'h80);
        send_pixel(8'h01, 8'hFE, 8'h7F);
        settle();

        // zero factor and zero size: every pixel is a one-pixel frame
        set_geometry(0, 0, 0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        settle();

        // 3x2 with factor 2: right column dropped, then wrap into a new frame
        set_geometry(3, 2, 2);
        send_pixel(8'hFF, 8'h00, 8'h80);
        send_pixel(8'hFF, 8'h00, 8'h01);
        send_pixel(8'h07, 8'h07, 8'h07);
        send_pixel(8'hFF, 8'h00, 8'hAA);
        send_pixel(8'hFF, 8'h00, 8'h55);
        send_pixel(8'h09, 8'h09, 8'h09);
        send_pixel(8'h01, 8'h02, 8'h03);
        settle();

        // a write to the spare index must not restart the frame
        set_geometry(2, 2, 1);
        send_pixel(8'h10, 8'h20, 8'h30);
        settle();
        write_reg(REG_SPARE, CFG_DATA_BITS'($urandom), 1'b1);
        send_pixel(8'hAA, 8'h55, 8'hFF);
        send_pixel(8'h55, 8'hAA, 8'h00);
        send_pixel(8'hF0, 8'h0F, 8'hC3);
        settle();

        // reduced image is empty: pixels counted, nothing sent
        set_geometry(1, 5, 2);
        send_random_pixels(3);
        settle();

        // oversized factor and width clamp
        set_geometry(8191, 8191, 31);
        send_random_pixels(2);
        settle();

        // hold off the result side while the source keeps streaming
        src_idle <= 1'b0;
        set_geometry($urandom_range(2, 8), $urandom_range(2, 8), 1);
        hold_requests <= 1;
        send_random_pixels(40);
        sent += 40;
        settle();

        // full-size square: one mean over 256 pixels
        src_idle <= 1'b1;
        set_geometry(MAX_FACTOR, MAX_FACTOR, MAX_FACTOR);
        send_random_pixels(MAX_FACTOR * MAX_FACTOR);
        sent += MAX_FACTOR * MAX_FACTOR;
        settle();

        while (sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                f = 0;
            else if (sel == 1)
                f = $urandom_range(MAX_FACTOR, 31);
            else
                f = $urandom_range(1, 4);
            ef = (f == 0) ? 1 : (f > MAX_FACTOR) ? MAX_FACTOR : f;
            sel = $urandom_range(0, 7);
            if (sel == 0)
                w = $urandom_range(MAX_WIDTH, 8191);
            else if (sel == 1)
                w = $urandom_range(0, ef - 1);
            else
                w = (ef > 4) ? ef + $urandom_range(0, 2) : $urandom_range(ef, 3 * ef + 2);
            sel = $urandom_range(0, 7);
            if (sel == 0)
                h = $urandom_range(MAX_WIDTH, 8191);
            else if (sel == 1)
                h = $urandom_range(0, ef - 1);
            else
                h = (ef > 4) ? ef : $urandom_range(ef, 2 * ef + 3);
            ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
            eh = (h == 0) ? 1 : h;
            // mostly whole frames, sometimes a frame cut short
            if (ew * eh <= 200 && $urandom_range(0, 3) != 0)
                n = ew * eh * ((ew * eh <= 60) ? $urandom_range(1, 3) : 1);
            else
                n = $urandom_range(1, 40);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            if (sent + n >= RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            src_idle <= ($urandom_range(0, 3) != 0);
            set_geometry(w, h, f);
            send_random_pixels(n);
            sent += n;
            settle();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bda_pkg.sv
rtl/core/bda_ram.sv
rtl/core/bda_div.sv
rtl/core/bda_ctrl.sv
rtl/core/bda_datapath.sv
rtl/core/box_downscale_average_unit.sv
bench/tb_box_downscale_average_unit.sv
